/* rtl/sfm_pkg.sv */
// ----------------------------------------------------------------------------
// sfm_pkg
// Shared types and constants for the first-match substring search block.
// ----------------------------------------------------------------------------
package sfm_pkg;

	localparam int MAX_NEEDLE   = 32;
	localparam int MAX_HAYSTACK = 65536;

	localparam int DATA_W   = 8;
	localparam int MODE_W   = 2;
	localparam int POS_W    = 17;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = $clog2(MAX_NEEDLE + 1);
	localparam int IDX_W    = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
	localparam int CNT_W    = $clog2(MAX_HAYSTACK + 1);
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [MODE_W-1:0] MODE_NEEDLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEGIN  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HAY    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_END    = 2'd3;

	localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NDL_LONG  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_HAY_LONG  = 2'd3;

	// broadcast control from the top level to every cell
	typedef struct packed {
		logic              shift;
		logic              load;
		logic              clear;
		logic [DATA_W-1:0] data;
	} cell_ctrl_t;

endpackage

/* rtl/sfm_cell.sv */
// ----------------------------------------------------------------------------
// sfm_cell
// One needle byte and its partial-match flag; the flag takes its neighbor's
// flag on each haystack byte while the cell is active and the stored byte matches.
// ----------------------------------------------------------------------------
module sfm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sfm_pkg::cell_ctrl_t ctrl,
	input  logic               sel,
	input  logic               active,
	input  logic               chain_in,
	output logic               match_next,
	output logic               match_q
);
	import sfm_pkg::*;

	logic [DATA_W-1:0] needle_q;

	assign match_next = chain_in && (needle_q == ctrl.data);

	always_ff @(posedge clk) begin
		if (ctrl.load && sel) begin
			needle_q <= ctrl.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.clear) begin
			match_q <= 1'b0;
		end else if (ctrl.shift && active) begin
			match_q <= match_next;
		end
	end

endmodule

/* rtl/substring_first_match.sv */
// ----------------------------------------------------------------------------
// substring_first_match
// Streaming search for the first offset of a loaded needle in a haystack.
// ----------------------------------------------------------------------------
// Usage: every request on the req channel is one of four kinds, chosen by
// mode. Needle bytes load a row of compare cells (first_of_needle restarts
// the needle). A begin request latches start_position and clears the search.
// Haystack bytes then stream in; each one is compared against all needle
// bytes at once in the cell row, so one request is taken every cycle unless
// an end request is stalled. An end request produces one response (status,
// match_position) on the res channel, registered, in the cycle after the
// request is taken; the search is left intact so a repeated end gives the
// same answer. Throughput is one request per cycle, bar a stalled end request,
// set by the cell row update and the match check on the last needle cell.
// Reset clears needle length, all flags, counters and the response valid flag;
// needle bytes and the response status/position are not reset. While the
// receiver stalls a pending response, needle, begin and haystack requests are
// still taken; only a new end request is stalled until the response is taken.
// ----------------------------------------------------------------------------
module substring_first_match (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic [sfm_pkg::MODE_W-1:0] mode,
	input  logic [sfm_pkg::DATA_W-1:0] byte_value,
	input  logic                      first_of_needle,
	input  logic [sfm_pkg::POS_W-1:0]  start_position,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic [sfm_pkg::STATUS_W-1:0] status,
	output logic [sfm_pkg::POS_W-1:0]  match_position
);
	import sfm_pkg::*;

	logic [LEN_W-1:0]    len_q;
	logic                ndl_ovf_q;
	logic [CNT_W-1:0]    count_q;
	logic [POS_W-1:0]    start_q;
	logic                found_q;
	logic [POS_W-1:0]    offset_q;
	logic                hay_ovf_q;
	logic                res_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [POS_W-1:0]    pos_q;

	logic                accept;
	logic                res_take;
	logic [LEN_W-1:0]    wr_len;
	logic [IDX_W-1:0]    wr_idx;
	logic                hay_room;
	cell_ctrl_t          ctrl;
	logic [MAX_NEEDLE-1:0] sel;
	logic [MAX_NEEDLE-1:0] active;
	logic [MAX_NEEDLE-1:0] chain;
	logic [MAX_NEEDLE-1:0] match_next;
	logic [MAX_NEEDLE-1:0] match_q;
	logic [LEN_W-1:0]    last_len;
	logic                hit;
	logic [CNT_W-1:0]    cnt_inc;
	logic [CNT_W-1:0]    begin_ofs;
	logic                long_enough;
	logic                after_start;
	logic                empty_ok;
	logic [STATUS_W-1:0] status_d;
	logic [POS_W-1:0]    pos_d;

	assign res_take  = res_valid_q && !res_stall;
	assign req_stall = res_valid_q && res_stall && (mode == MODE_END);
	assign accept    = req_valid && !req_stall;

	assign wr_len   = first_of_needle ? '0 : len_q;
	assign wr_idx   = wr_len[IDX_W-1:0];
	assign hay_room = (count_q < CNT_W'(MAX_HAYSTACK));

	always_comb begin
		ctrl.data  = byte_value;
		ctrl.load  = accept && (mode == MODE_NEEDLE) && (wr_len < LEN_W'(MAX_NEEDLE));
		ctrl.shift = accept && (mode == MODE_HAY) && hay_room;
		ctrl.clear = accept && (mode == MODE_BEGIN);
	end

	genvar k;
	generate
		for (k = 0; k < MAX_NEEDLE; k++) begin : g_cell
			assign sel[k]    = (wr_idx == IDX_W'(k));
			assign active[k] = (LEN_W'(k) < len_q);
			if (k == 0) begin : g_head
				assign chain[k] = 1'b1;
			end else begin : g_link
				assign chain[k] = match_q[k-1];
			end
			sfm_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.sel        (sel[k]),
				.active     (active[k]),
				.chain_in   (chain[k]),
				.match_next (match_next[k]),
				.match_q    (match_q[k])
			);
		end
	endgenerate

	// full match ends at this byte when the last needle cell matches
	assign last_len    = len_q - LEN_W'(1);
	assign hit         = (len_q != '0) && match_next[last_len[IDX_W-1:0]];
	assign cnt_inc     = count_q + CNT_W'(1);
	assign long_enough = (cnt_inc >= CNT_W'(len_q));
	assign begin_ofs   = cnt_inc - CNT_W'(len_q);
	assign after_start = (CMP_W'(begin_ofs) >= CMP_W'(start_q));
	assign empty_ok    = (CMP_W'(start_q) <= CMP_W'(count_q));

	always_comb begin
		pos_d = '0;
		if (ndl_ovf_q) begin
			status_d = ST_NDL_LONG;
		end else if (hay_ovf_q) begin
			status_d = ST_HAY_LONG;
		end else if (len_q == '0) begin
			if (empty_ok) begin
				status_d = ST_FOUND;
				pos_d    = start_q;
			end else begin
				status_d = ST_NOT_FOUND;
			end
		end else if (found_q) begin
			status_d = ST_FOUND;
			pos_d    = offset_q;
		end else begin
			status_d = ST_NOT_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			ndl_ovf_q <= 1'b0;
			count_q   <= '0;
			start_q   <= '0;
			found_q   <= 1'b0;
			offset_q  <= '0;
			hay_ovf_q <= 1'b0;
		end else if (accept) begin
			case (mode)
				MODE_NEEDLE: begin
					if (wr_len < LEN_W'(MAX_NEEDLE)) begin
						len_q     <= wr_len + LEN_W'(1);
						ndl_ovf_q <= first_of_needle ? 1'b0 : ndl_ovf_q;
					end else begin
						len_q     <= wr_len;
						ndl_ovf_q <= 1'b1;
					end
				end
				MODE_BEGIN: begin
					start_q   <= start_position;
					count_q   <= '0;
					found_q   <= 1'b0;
					offset_q  <= '0;
					hay_ovf_q <= 1'b0;
				end
				MODE_HAY: begin
					if (!hay_room) begin
						hay_ovf_q <= 1'b1;
					end else begin
						count_q <= cnt_inc;
						if (hit && long_enough && !found_q && after_start) begin
							found_q  <= 1'b1;
							offset_q <= POS_W'(begin_ofs);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && (mode == MODE_END)) begin
			res_valid_q <= 1'b1;
		end else if (res_take) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (mode == MODE_END)) begin
			status_q <= status_d;
			pos_q    <= pos_d;
		end
	end

	assign res_valid      = res_valid_q;
	assign status         = status_q;
	assign match_position = pos_q;

endmodule
